// ----- hdl/mfba_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfba_pkg: shared types and constants of the message FIFO
// Status codes, request kinds and the front-to-back transaction record.
// ----------------------------------------------------------------------------
package mfba_pkg;

  localparam int unsigned StoreBytesDefault  = 4096;
  localparam int unsigned MaxMessagesDefault = 256;

  localparam int unsigned SegmentLimit = 1024;
  localparam int unsigned LenW         = 11;
  localparam int unsigned ReqLenW      = 16;
  localparam int unsigned DataW        = 8;
  localparam int unsigned StatusW      = 3;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_SIZE  = 3'd1,
    ST_NO_SPACE  = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_TOO_SMALL = 3'd4,
    ST_DISCARD   = 3'd5
  } status_e;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [ReqLenW-1:0] len;
    logic [DataW-1:0]   data;
  } item_t;

endpackage

// ----- hdl/mfba_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfba_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mfba_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/mfba_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfba_front: request intake
// Accepts start transactions, classifies them and buffers them in a
// two-entry queue towards the execution side.
// ----------------------------------------------------------------------------
module mfba_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic                           req_type_i,
  input  logic [mfba_pkg::ReqLenW-1:0]   req_len_i,
  input  logic [mfba_pkg::DataW-1:0]     data_in_i,
  output logic                           item_valid_o,
  output mfba_pkg::item_t                item_o,
  input  logic                           item_pop_i
);

  mfba_pkg::item_t entry_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      count_q, count_d;
  logic            push;
  logic            pop;
  mfba_pkg::item_t in_item;

  always_comb begin
    in_item.op   = req_type_i ? mfba_pkg::OP_READ : mfba_pkg::OP_WRITE;
    in_item.len  = req_len_i;
    in_item.data = data_in_i;
  end

  assign busy_o       = (count_q == 2'd2);
  assign push         = start_i && !busy_o;
  assign item_valid_o = (count_q != 2'd0);
  assign pop          = item_pop_i && item_valid_o;
  assign item_o       = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    case ({push, pop})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= in_item;
    end
  end

endmodule

// ----- hdl/mfba_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfba_back: message execution
// Holds the byte store, length queue and accounting state; carries out one
// byte write or byte read per transaction and registers the result.
// ----------------------------------------------------------------------------
module mfba_back #(
  parameter int unsigned StoreBytes  = mfba_pkg::StoreBytesDefault,
  parameter int unsigned MaxMessages = mfba_pkg::MaxMessagesDefault,
  localparam int unsigned UsedW      = $clog2(StoreBytes + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mfba_pkg::LenW-1:0]     cfg_wdata_i,
  input  logic                          item_valid_i,
  input  mfba_pkg::item_t               item_i,
  output logic                          item_pop_o,
  output logic                          done_o,
  output logic [mfba_pkg::StatusW-1:0]  status_o,
  output logic [mfba_pkg::DataW-1:0]    data_out_o,
  output logic                          byte_last_o,
  output logic [mfba_pkg::LenW-1:0]     msg_len_o,
  output logic [UsedW-1:0]              free_bytes_o
);

  localparam int unsigned PtrW = $clog2(StoreBytes);
  localparam int unsigned QW   = $clog2(MaxMessages);
  localparam int unsigned CntW = $clog2(MaxMessages + 1);
  localparam int unsigned LenW = mfba_pkg::LenW;
  localparam int unsigned CmpW = (UsedW > mfba_pkg::ReqLenW) ? UsedW : mfba_pkg::ReqLenW;

  typedef enum logic [1:0] {
    BK_IDLE = 2'b01,
    BK_READ = 2'b10
  } state_e;

  function automatic logic [PtrW-1:0] bump_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(StoreBytes - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [QW-1:0] bump_q(input logic [QW-1:0] p);
    return (p == QW'(MaxMessages - 1)) ? '0 : p + 1'b1;
  endfunction

  state_e              state_q, state_d;
  mfba_pkg::item_t     item_q, item_d;
  logic [LenW-1:0]     max_seg_q, max_seg_d;
  logic [PtrW-1:0]     wp_q, wp_d, rp_q, rp_d;
  logic [QW-1:0]       head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [UsedW-1:0]    used_q, used_d;
  logic [LenW-1:0]     wrem_q, wrem_d, rrem_q, rrem_d;
  logic                wdisc_q, wdisc_d;
  logic [LenW-1:0]     wlen_q, wlen_d, rlen_q, rlen_d;

  logic                    done_q, done_d;
  mfba_pkg::status_e       status_q, status_d;
  logic [mfba_pkg::DataW-1:0] dout_q, dout_d;
  logic                    last_q, last_d;
  logic [LenW-1:0]         mlen_q, mlen_d;

  logic                    byte_we;
  logic                    len_we;
  logic [mfba_pkg::DataW-1:0] byte_rdata;
  logic [LenW-1:0]         len_rdata;
  logic [UsedW-1:0]        free_now;
  logic [CmpW-1:0]         req_len_x;
  logic [CmpW-1:0]         free_x;
  logic [CmpW-1:0]         hlen_x;
  logic [LenW-1:0]         req_len_n;

  mfba_ram #(
    .Width (mfba_pkg::DataW),
    .Depth (StoreBytes)
  ) u_byte_store (
    .clk_i   (clk_i),
    .we_i    (byte_we),
    .waddr_i (wp_q),
    .wdata_i (item_i.data),
    .raddr_i (rp_q),
    .rdata_o (byte_rdata)
  );

  mfba_ram #(
    .Width (LenW),
    .Depth (MaxMessages)
  ) u_length_queue (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (tail_q),
    .wdata_i (req_len_n),
    .raddr_i (head_q),
    .rdata_o (len_rdata)
  );

  assign free_now  = UsedW'(StoreBytes) - used_q;
  assign req_len_x = CmpW'(item_i.len);
  assign free_x    = CmpW'(free_now);
  assign hlen_x    = CmpW'(len_rdata);
  assign req_len_n = item_i.len[LenW-1:0];

  always_comb begin
    max_seg_d = max_seg_q;
    if (cfg_we_i && (cfg_wdata_i <= LenW'(mfba_pkg::SegmentLimit))) begin
      max_seg_d = cfg_wdata_i;
    end
  end

  always_comb begin
    state_d    = state_q;
    item_d     = item_q;
    wp_d       = wp_q;
    rp_d       = rp_q;
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    used_d     = used_q;
    wrem_d     = wrem_q;
    rrem_d     = rrem_q;
    wdisc_d    = wdisc_q;
    wlen_d     = wlen_q;
    rlen_d     = rlen_q;
    done_d     = 1'b0;
    status_d   = mfba_pkg::ST_OK;
    dout_d     = '0;
    last_d     = 1'b0;
    mlen_d     = '0;
    item_pop_o = 1'b0;
    byte_we    = 1'b0;
    len_we     = 1'b0;

    case (state_q)
      BK_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          if (item_i.op == mfba_pkg::OP_READ) begin
            item_d  = item_i;
            state_d = BK_READ;
          end else begin
            done_d = 1'b1;
            if (wrem_q != '0) begin
              wrem_d = wrem_q - 1'b1;
              last_d = (wrem_q == LenW'(1));
              if (wdisc_q) begin
                status_d = mfba_pkg::ST_DISCARD;
                if (wrem_q == LenW'(1)) begin
                  wdisc_d = 1'b0;
                end
              end else begin
                mlen_d  = wlen_q;
                byte_we = 1'b1;
                wp_d    = bump_ptr(wp_q);
                if (wrem_q == LenW'(1)) begin
                  tail_d  = bump_q(tail_q);
                  count_d = count_q + 1'b1;
                end
              end
            end else if ((item_i.len == '0) ||
                         (item_i.len > mfba_pkg::ReqLenW'(max_seg_q))) begin
              status_d = mfba_pkg::ST_BAD_SIZE;
            end else if ((free_now == '0) || (req_len_x > free_x) ||
                         (count_q == CntW'(MaxMessages))) begin
              status_d = mfba_pkg::ST_NO_SPACE;
              wrem_d   = req_len_n - 1'b1;
              wdisc_d  = (req_len_n != LenW'(1));
              last_d   = (req_len_n == LenW'(1));
            end else begin
              len_we  = 1'b1;
              mlen_d  = req_len_n;
              wlen_d  = req_len_n;
              used_d  = used_q + UsedW'(req_len_n);
              byte_we = 1'b1;
              wp_d    = bump_ptr(wp_q);
              wrem_d  = req_len_n - 1'b1;
              wdisc_d = 1'b0;
              if (req_len_n == LenW'(1)) begin
                last_d  = 1'b1;
                tail_d  = bump_q(tail_q);
                count_d = count_q + 1'b1;
              end
            end
          end
        end
      end
      BK_READ: begin
        done_d  = 1'b1;
        state_d = BK_IDLE;
        if (rrem_q != '0) begin
          mlen_d = rlen_q;
          dout_d = byte_rdata;
          rp_d   = bump_ptr(rp_q);
          rrem_d = rrem_q - 1'b1;
          if (rrem_q == LenW'(1)) begin
            last_d  = 1'b1;
            used_d  = (used_q >= UsedW'(rlen_q)) ? used_q - UsedW'(rlen_q) : '0;
            head_d  = bump_q(head_q);
            count_d = count_q - 1'b1;
          end
        end else if (item_q.len == '0) begin
          status_d = mfba_pkg::ST_BAD_SIZE;
        end else if (count_q == '0) begin
          status_d = mfba_pkg::ST_EMPTY;
        end else if (CmpW'(item_q.len) < hlen_x) begin
          status_d = mfba_pkg::ST_TOO_SMALL;
        end else begin
          mlen_d = len_rdata;
          rlen_d = len_rdata;
          dout_d = byte_rdata;
          rp_d   = bump_ptr(rp_q);
          rrem_d = (len_rdata != '0) ? len_rdata - 1'b1 : '0;
          if (len_rdata <= LenW'(1)) begin
            last_d  = 1'b1;
            used_d  = (used_q >= UsedW'(len_rdata)) ? used_q - UsedW'(len_rdata) : '0;
            head_d  = bump_q(head_q);
            count_d = count_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      max_seg_q <= LenW'(mfba_pkg::SegmentLimit);
      wp_q      <= '0;
      rp_q      <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      count_q   <= '0;
      used_q    <= '0;
      wrem_q    <= '0;
      rrem_q    <= '0;
      wdisc_q   <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      max_seg_q <= max_seg_d;
      wp_q      <= wp_d;
      rp_q      <= rp_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      count_q   <= count_d;
      used_q    <= used_d;
      wrem_q    <= wrem_d;
      rrem_q    <= rrem_d;
      wdisc_q   <= wdisc_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    wlen_q   <= wlen_d;
    rlen_q   <= rlen_d;
    status_q <= status_d;
    dout_q   <= dout_d;
    last_q   <= last_d;
    mlen_q   <= mlen_d;
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign data_out_o   = dout_q;
  assign byte_last_o  = last_q;
  assign msg_len_o    = mlen_q;
  assign free_bytes_o = free_now;

endmodule

// ----- hdl/message_fifo_byte_accounting.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// message_fifo_byte_accounting: variable-length message FIFO
// done_o strobes after the front queue and result registers; reads also pass BK_READ.
// Throughput: one write byte per cycle while no read is in progress; each read
// also passes BK_READ for the registered read port of the byte store.
// Reset clears pointers, counters and open-message state; the byte store and
// length queue are not cleared and need no clearing pass.
// The receiver cannot stall: each result is shown for one cycle with done_o.
// ----------------------------------------------------------------------------
module message_fifo_byte_accounting #(
  parameter int unsigned StoreBytes  = mfba_pkg::StoreBytesDefault,
  parameter int unsigned MaxMessages = mfba_pkg::MaxMessagesDefault,
  localparam int unsigned FreeW      = $clog2(StoreBytes + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          req_type_i,
  input  logic [mfba_pkg::ReqLenW-1:0]  req_len_i,
  input  logic [mfba_pkg::DataW-1:0]    data_in_i,
  input  logic                          cfg_we_i,
  input  logic [mfba_pkg::LenW-1:0]     cfg_wdata_i,
  output logic                          done_o,
  output logic [mfba_pkg::StatusW-1:0]  status_o,
  output logic [mfba_pkg::DataW-1:0]    data_out_o,
  output logic                          byte_last_o,
  output logic [mfba_pkg::LenW-1:0]     msg_len_o,
  output logic [FreeW-1:0]              free_bytes_o
);

  logic            item_valid;
  mfba_pkg::item_t item;
  logic            item_pop;

  mfba_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .req_type_i   (req_type_i),
    .req_len_i    (req_len_i),
    .data_in_i    (data_in_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  mfba_back #(
    .StoreBytes  (StoreBytes),
    .MaxMessages (MaxMessages)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .done_o       (done_o),
    .status_o     (status_o),
    .data_out_o   (data_out_o),
    .byte_last_o  (byte_last_o),
    .msg_len_o    (msg_len_o),
    .free_bytes_o (free_bytes_o)
  );

endmodule

// ----- sim/message_fifo_byte_accounting_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// message_fifo_byte_accounting_tb: self-checking bench for the message FIFO
// Drives one byte transaction at a time through the start/busy handshake and
// checks every done_o strobe against a cycle-free model of the FIFO. The run
// covers a table of directed bytes, a fill of the length queue, and random
// message traffic under several segment limits, with random sender gaps and
// waits for all pending results between phases.
// ----------------------------------------------------------------------------
module message_fifo_byte_accounting_tb;
  import mfba_pkg::*;

  localparam int unsigned StoreBytes   = StoreBytesDefault;
  localparam int unsigned MaxMessages  = MaxMessagesDefault;
  localparam int unsigned ClkPeriod    = 20;
  localparam int unsigned CycleLimit   = 1000000;
  localparam int unsigned PhaseItems   = 130;
  localparam int unsigned DirectedRows = 21;

  typedef struct packed {
    status_e          status;
    logic [DataW-1:0] data;
    logic             last;
    logic [LenW-1:0]  mlen;
    logic [12:0]      free;
  } byte_result_t;

  typedef struct {
    op_e                op;
    logic [ReqLenW-1:0] len;
    logic [DataW-1:0]   data;
    bit                 typed;
    byte_result_t       res;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic                busy_o;
  logic                req_type_i = 1'b0;
  logic [ReqLenW-1:0]  req_len_i = '0;
  logic [DataW-1:0]    data_in_i = '0;
  logic                cfg_we_i = 1'b0;
  logic [LenW-1:0]     cfg_wdata_i = '0;
  logic                done_o;
  logic [StatusW-1:0]  status_o;
  logic [DataW-1:0]    data_out_o;
  logic                byte_last_o;
  logic [LenW-1:0]     msg_len_o;
  logic [12:0]         free_bytes_o;

  message_fifo_byte_accounting u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_type_i  (req_type_i),
    .req_len_i   (req_len_i),
    .data_in_i   (data_in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .data_out_o  (data_out_o),
    .byte_last_o (byte_last_o),
    .msg_len_o   (msg_len_o),
    .free_bytes_o(free_bytes_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Mirror of the FIFO state
  logic [DataW-1:0] mirror_bytes   [StoreBytes];
  logic [LenW-1:0]  mirror_lengths [MaxMessages];
  logic [11:0]      wr_addr = '0;
  logic [11:0]      rd_addr = '0;
  logic [7:0]       msg_head = '0;
  logic [7:0]       msg_tail = '0;
  int unsigned      msg_count = 0;
  int unsigned      bytes_reserved = 0;
  int unsigned      wr_bytes_left = 0;
  bit               wr_dropping = 1'b0;
  int unsigned      rd_bytes_left = 0;
  int unsigned      seg_max = SegmentLimit;

  byte_result_t     queued_byte_results [$];
  int unsigned      fail_count = 0;
  int unsigned      gap_ceiling = 15;
  int unsigned      cycle_count = 0;
  byte_result_t     observed;
  byte_result_t     awaited;
  logic [LenW-1:0]  seg_settings [7];

  stim_row_t directed_rows [DirectedRows] = '{
    '{OP_READ,  16'd0,     8'h00, 1'b1, '{ST_BAD_SIZE,  8'h00, 1'b0, 11'd0, 13'd4096}},
    '{OP_READ,  16'd100,   8'h00, 1'b1, '{ST_EMPTY,     8'h00, 1'b0, 11'd0, 13'd4096}},
    '{OP_WRITE, 16'd0,     8'h11, 1'b1, '{ST_BAD_SIZE,  8'h00, 1'b0, 11'd0, 13'd4096}},
    '{OP_WRITE, 16'd1025,  8'h22, 1'b1, '{ST_BAD_SIZE,  8'h00, 1'b0, 11'd0, 13'd4096}},
    '{OP_WRITE, 16'hFFFF,  8'h33, 1'b1, '{ST_BAD_SIZE,  8'h00, 1'b0, 11'd0, 13'd4096}},
    '{OP_WRITE, 16'd1,     8'hFF, 1'b1, '{ST_OK,        8'h00, 1'b1, 11'd1, 13'd4095}},
    '{OP_READ,  16'hFFFF,  8'h00, 1'b1, '{ST_OK,        8'hFF, 1'b1, 11'd1, 13'd4096}},
    '{OP_WRITE, 16'd3,     8'h00, 1'b1, '{ST_OK,        8'h00, 1'b0, 11'd3, 13'd4093}},
    '{OP_READ,  16'd5,     8'h00, 1'b1, '{ST_EMPTY,     8'h00, 1'b0, 11'd0, 13'd4093}},
    '{OP_WRITE, 16'hFFFF,  8'hA5, 1'b0, '0},
    '{OP_WRITE, 16'd0,     8'h5A, 1'b0, '0},
    '{OP_READ,  16'd2,     8'h00, 1'b1, '{ST_TOO_SMALL, 8'h00, 1'b0, 11'd0, 13'd4093}},
    '{OP_READ,  16'd3,     8'h00, 1'b0, '0},
    '{OP_WRITE, 16'd2,     8'hC3, 1'b0, '0},
    '{OP_READ,  16'd0,     8'h00, 1'b0, '0},
    '{OP_READ,  16'd0,     8'h00, 1'b0, '0},
    '{OP_READ,  16'd7,     8'h00, 1'b1, '{ST_EMPTY,     8'h00, 1'b0, 11'd0, 13'd4094}},
    '{OP_WRITE, 16'd0,     8'h3C, 1'b0, '0},
    '{OP_READ,  16'd1,     8'h00, 1'b1, '{ST_TOO_SMALL, 8'h00, 1'b0, 11'd0, 13'd4094}},
    '{OP_READ,  16'd2,     8'h00, 1'b0, '0},
    '{OP_READ,  16'd0,     8'h00, 1'b0, '0}
  };

  function automatic void release_head(int unsigned head_len);
    bytes_reserved = bytes_reserved - head_len;
    msg_head       = msg_head + 8'd1;
    msg_count      = msg_count - 1;
  endfunction

  function automatic byte_result_t predict_fifo_byte(op_e op, logic [ReqLenW-1:0] len,
                                                     logic [DataW-1:0] data);
    byte_result_t r;
    int unsigned  free_now;
    int unsigned  head_len;
    r        = '0;
    r.status = ST_OK;
    if (op == OP_WRITE) begin
      if (wr_bytes_left != 0) begin
        wr_bytes_left--;
        r.last = (wr_bytes_left == 0);
        if (wr_dropping) begin
          r.status = ST_DISCARD;
          if (r.last) wr_dropping = 1'b0;
        end else begin
          r.mlen               = mirror_lengths[msg_tail];
          mirror_bytes[wr_addr] = data;
          wr_addr              = wr_addr + 12'd1;
          if (r.last) begin
            msg_tail  = msg_tail + 8'd1;
            msg_count = msg_count + 1;
          end
        end
      end else begin
        free_now = StoreBytes - bytes_reserved;
        if (len == 0 || len > SegmentLimit || len > seg_max) begin
          r.status = ST_BAD_SIZE;
        end else if (free_now == 0 || len > free_now || msg_count >= MaxMessages) begin
          r.status      = ST_NO_SPACE;
          wr_bytes_left = len - 1;
          wr_dropping   = (wr_bytes_left != 0);
          r.last        = (wr_bytes_left == 0);
        end else begin
          mirror_lengths[msg_tail] = len[LenW-1:0];
          r.mlen                   = len[LenW-1:0];
          bytes_reserved           = bytes_reserved + len;
          mirror_bytes[wr_addr]    = data;
          wr_addr                  = wr_addr + 12'd1;
          wr_bytes_left            = len - 1;
          wr_dropping              = 1'b0;
          if (wr_bytes_left == 0) begin
            r.last    = 1'b1;
            msg_tail  = msg_tail + 8'd1;
            msg_count = msg_count + 1;
          end
        end
      end
    end else begin
      if (rd_bytes_left != 0) begin
        head_len = mirror_lengths[msg_head];
        r.mlen   = head_len[LenW-1:0];
        r.data   = mirror_bytes[rd_addr];
        rd_addr  = rd_addr + 12'd1;
        rd_bytes_left--;
        if (rd_bytes_left == 0) begin
          r.last = 1'b1;
          release_head(head_len);
        end
      end else if (len == 0) begin
        r.status = ST_BAD_SIZE;
      end else if (msg_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        head_len = mirror_lengths[msg_head];
        if (len < head_len) begin
          r.status = ST_TOO_SMALL;
        end else begin
          r.mlen        = head_len[LenW-1:0];
          r.data        = mirror_bytes[rd_addr];
          rd_addr       = rd_addr + 12'd1;
          rd_bytes_left = head_len - 1;
          if (rd_bytes_left == 0) begin
            r.last = 1'b1;
            release_head(head_len);
          end
        end
      end
    end
    r.free = 13'(StoreBytes - bytes_reserved);
    return r;
  endfunction

  task automatic send_byte(op_e op, logic [ReqLenW-1:0] len, logic [DataW-1:0] data,
                           bit typed = 1'b0, byte_result_t typed_res = '0);
    int unsigned  gap;
    byte_result_t predicted;
    gap = $urandom_range(0, gap_ceiling);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i    <= 1'b1;
    req_type_i <= op;
    req_len_i  <= len;
    data_in_i  <= data;
    forever begin
      @(posedge clk_i);
      if (!busy_o) break;
    end
    predicted = predict_fifo_byte(op, len, data);
    queued_byte_results.push_back(typed ? typed_res : predicted);
    @(negedge clk_i);
  endtask

  task automatic wait_results_drained();
    start_i <= 1'b0;
    do @(negedge clk_i); while (queued_byte_results.size() != 0);
  endtask

  task automatic write_segment_limit(logic [LenW-1:0] value);
    wait_results_drained();
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    if (value <= SegmentLimit) seg_max = value;
  endtask

  task automatic write_message(logic [ReqLenW-1:0] len);
    send_byte(OP_WRITE, len, 8'($urandom));
    while (wr_bytes_left != 0) send_byte(OP_WRITE, 16'($urandom), 8'($urandom));
  endtask

  task automatic drain_messages();
    int unsigned head_len;
    while (msg_count != 0) begin
      head_len = mirror_lengths[msg_head];
      send_byte(OP_READ, 16'(head_len + $urandom_range(0, 64)), 8'($urandom));
      while (rd_bytes_left != 0) send_byte(OP_READ, 16'($urandom), 8'($urandom));
    end
  endtask

  task automatic send_random_byte();
    op_e                op;
    logic [ReqLenW-1:0] len;
    int unsigned        pick;
    int unsigned        head_len;
    op   = ($urandom_range(0, 99) < 55) ? OP_WRITE : OP_READ;
    len  = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (op == OP_WRITE && wr_bytes_left == 0) begin
      if (pick < 85 && seg_max != 0) begin
        if ($urandom_range(0, 63) == 0) len = 16'($urandom_range(1, seg_max));
        else len = 16'($urandom_range(1, (seg_max < 16) ? seg_max : 16));
      end else if (pick < 90) begin
        len = '0;
      end else if (pick < 95) begin
        len = 16'($urandom_range(seg_max + 1, SegmentLimit + 1));
      end
    end else if (op == OP_READ && rd_bytes_left == 0 && msg_count != 0) begin
      head_len = mirror_lengths[msg_head];
      if (pick < 75) len = 16'(head_len + $urandom_range(0, 3));
      else if (pick < 82) len = '1;
      else if (pick < 90 && head_len > 1) len = 16'($urandom_range(1, head_len - 1));
      else if (pick < 95) len = '0;
    end
    send_byte(op, len, 8'($urandom));
  endtask

  always @(posedge clk_i) begin
    if (done_o) begin
      observed.status = status_e'(status_o);
      observed.data   = data_out_o;
      observed.last   = byte_last_o;
      observed.mlen   = msg_len_o;
      observed.free   = free_bytes_o;
      if (queued_byte_results.size() == 0) begin
        if (fail_count < 10)
          $display("%0t: unexpected result status %0d data %02h", $realtime,
                   status_o, data_out_o);
        fail_count++;
      end else begin
        awaited = queued_byte_results.pop_front();
        if (observed !== awaited) begin
          if (fail_count < 10) begin
            $write("%0t: mismatch exp status %0d data %02h last %0b len %0d free %0d",
                   $realtime, awaited.status, awaited.data, awaited.last, awaited.mlen,
                   awaited.free);
            $display(" / got status %0d data %02h last %0b len %0d free %0d",
                     observed.status, observed.data, observed.last, observed.mlen,
                     observed.free);
          end
          fail_count++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    seg_settings = '{11'd16, 11'd1025, 11'd0, 11'd1, 11'd2047,
                     11'($urandom_range(2, 1023)), 11'd1024};
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i])
      send_byte(directed_rows[i].op, directed_rows[i].len, directed_rows[i].data,
                directed_rows[i].typed, directed_rows[i].res);

    // fill the length queue with single-byte messages, then write against the full queue
    gap_ceiling = 15;
    repeat (MaxMessages) write_message(16'd1);
    write_message(16'd1);
    write_message(16'd3);
    drain_messages();

    foreach (seg_settings[p]) begin
      write_segment_limit(seg_settings[p]);
      repeat (PhaseItems) begin
        if ($urandom_range(0, 39) == 0) gap_ceiling = (gap_ceiling == 0) ? 15 : 0;
        if ($urandom_range(0, 79) == 0) wait_results_drained();
        send_random_byte();
      end
    end

    wait_results_drained();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/mfba_pkg.sv
hdl/mfba_ram.sv
hdl/mfba_front.sv
hdl/mfba_back.sv
hdl/message_fifo_byte_accounting.sv
sim/message_fifo_byte_accounting_tb.sv
